// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the record sequence checker.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/hrsc_pkg.sv -----
// Types, codes and reset values for the record sequence checker.
// No dependencies; imported by hrsc_check and the top level.
package hrsc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGING_CAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_END  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_UPLOAD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_ADDR   = 3'd4;

    localparam logic [31:0] RST_IMAGE_BASE  = 32'h6000_0000;
    localparam logic [31:0] RST_STAGING_CAP = 32'h007C_0000;
    localparam logic [31:0] RST_PROGRAM_END = 32'h60FC_0000;
    localparam logic [31:0] RST_MAX_UPLOAD  = 32'h0400_0000;
    localparam logic [31:0] RST_ENTRY_ADDR  = 32'h6000_1000;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_ABORT  = 2'd3;

    localparam logic [7:0] REC_DATA   = 8'h00;
    localparam logic [7:0] REC_EOF    = 8'h01;
    localparam logic [7:0] REC_EXT    = 8'h04;
    localparam logic [7:0] REC_START  = 8'h05;

    localparam logic [7:0] EXT_COUNT   = 8'd2;
    localparam logic [7:0] START_COUNT = 8'd4;

    localparam logic [1:0] FK_NONE    = 2'd0;
    localparam logic [1:0] FK_STATE   = 2'd1;
    localparam logic [1:0] FK_INVALID = 2'd2;

    localparam logic [4:0] EC_NONE          = 5'd0;
    localparam logic [4:0] EC_ACTIVE        = 5'd1;
    localparam logic [4:0] EC_AWAITING      = 5'd2;
    localparam logic [4:0] EC_LENGTH        = 5'd3;
    localparam logic [4:0] EC_NOT_ACTIVE    = 5'd4;
    localparam logic [4:0] EC_AFTER_EOF     = 5'd5;
    localparam logic [4:0] EC_DATA_AFTER_ST = 5'd6;
    localparam logic [4:0] EC_MISALIGNED    = 5'd7;
    localparam logic [4:0] EC_GAP           = 5'd8;
    localparam logic [4:0] EC_RANGE         = 5'd9;
    localparam logic [4:0] EC_EOF_BAD       = 5'd10;
    localparam logic [4:0] EC_MISSING       = 5'd11;
    localparam logic [4:0] EC_EXT_BAD       = 5'd12;
    localparam logic [4:0] EC_START_BAD     = 5'd13;
    localparam logic [4:0] EC_ENTRY         = 5'd14;
    localparam logic [4:0] EC_TYPE          = 5'd15;
    localparam logic [4:0] EC_NO_EOF        = 5'd16;

    typedef struct packed {
        logic [31:0] image_base;
        logic [31:0] stage_capacity;
        logic [31:0] program_end;
        logic [31:0] max_upload_length;
        logic [31:0] entry_address;
    } cfg_t;

    typedef struct packed {
        logic [15:0] upper_address;
        logic [31:0] next_address;
        logic [31:0] data_records;
        logic [31:0] image_bytes;
        logic        upload_active;
        logic        install_ready;
        logic        seen_data;
        logic        seen_start;
        logic        seen_eof;
    } state_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  failure_kind;
        logic [4:0]  error_code;
        logic        stage_write;
        logic [31:0] stage_offset;
        logic [7:0]  stage_length;
        logic [31:0] record_count;
        logic [31:0] image_size;
        logic        ready_res;
        logic        active;
    } result_t;

endpackage

// ----- src/hrsc_check.sv -----
// Combinational check of one item against the upload state.
// Depends on hrsc_pkg; instantiated by hex_record_sequence_checker_core.
module hrsc_check
    import hrsc_pkg::*;
(
    input  cfg_t        cfg,
    input  state_t      st,
    input  logic [1:0]  cmd,
    input  logic [31:0] upload_length,
    input  logic [7:0]  rec_type,
    input  logic [7:0]  rec_byte_count,
    input  logic [15:0] rec_offset,
    input  logic [31:0] rec_head_word,
    output state_t      st_next,
    output result_t     res
);

    logic [31:0] addr;
    logic [32:0] rec_end;
    logic [32:0] stage_limit;

    assign addr        = {st.upper_address, rec_offset};
    assign rec_end     = {1'b0, addr} + {25'd0, rec_byte_count};
    assign stage_limit = {1'b0, cfg.image_base} + {1'b0, cfg.stage_capacity};

    always_comb
    begin
        logic       ok;
        logic       clear_flags;
        logic [1:0] kind;
        logic [4:0] code;

        st_next     = st;
        ok          = 1'b1;
        clear_flags = 1'b0;
        kind        = FK_NONE;
        code        = EC_NONE;
        res.stage_write  = 1'b0;
        res.stage_offset = 32'd0;
        res.stage_length = 8'd0;

        case (cmd)
            CMD_BEGIN:
            begin
                if (st.upload_active)
                begin
                    ok   = 1'b0;
                    kind = FK_STATE;
                    code = EC_ACTIVE;
                end
                else if (st.install_ready)
                begin
                    ok   = 1'b0;
                    kind = FK_STATE;
                    code = EC_AWAITING;
                end
                else
                begin
                    st_next.upper_address = 16'd0;
                    st_next.next_address  = cfg.image_base;
                    st_next.image_bytes   = 32'd0;
                    st_next.data_records  = 32'd0;
                    st_next.seen_data     = 1'b0;
                    st_next.seen_start    = 1'b0;
                    st_next.seen_eof      = 1'b0;
                    st_next.install_ready = 1'b0;
                    if (upload_length == 32'd0 || upload_length > cfg.max_upload_length)
                    begin
                        ok          = 1'b0;
                        clear_flags = 1'b1;
                        kind        = FK_INVALID;
                        code        = EC_LENGTH;
                    end
                    else
                    begin
                        st_next.upload_active = 1'b1;
                    end
                end
            end
            CMD_RECORD:
            begin
                ok          = 1'b0;
                clear_flags = 1'b1;
                kind        = FK_INVALID;
                if (!st.upload_active || st.install_ready)
                begin
                    kind = FK_STATE;
                    code = EC_NOT_ACTIVE;
                end
                else if (st.seen_eof)
                begin
                    code = EC_AFTER_EOF;
                end
                else
                begin
                    case (rec_type)
                        REC_DATA:
                        begin
                            if (st.seen_start)
                                code = EC_DATA_AFTER_ST;
                            else if (rec_byte_count == 8'd0 || rec_offset[1:0] != 2'd0
                                     || rec_byte_count[1:0] != 2'd0)
                                code = EC_MISALIGNED;
                            else if (addr != st.next_address)
                                code = EC_GAP;
                            else if (addr < cfg.image_base || rec_end > stage_limit
                                     || rec_end > {1'b0, cfg.program_end})
                                code = EC_RANGE;
                            else
                            begin
                                ok                   = 1'b1;
                                clear_flags          = 1'b0;
                                kind                 = FK_NONE;
                                res.stage_write      = 1'b1;
                                res.stage_offset     = addr - cfg.image_base;
                                res.stage_length     = rec_byte_count;
                                st_next.next_address = rec_end[31:0];
                                st_next.seen_data    = 1'b1;
                                st_next.data_records = st.data_records + 32'd1;
                            end
                        end
                        REC_EOF:
                        begin
                            if (rec_byte_count != 8'd0 || rec_offset != 16'd0)
                                code = EC_EOF_BAD;
                            else if (!st.seen_data || !st.seen_start)
                                code = EC_MISSING;
                            else
                            begin
                                ok               = 1'b1;
                                clear_flags      = 1'b0;
                                kind             = FK_NONE;
                                st_next.seen_eof = 1'b1;
                            end
                        end
                        REC_EXT:
                        begin
                            if (st.seen_start || rec_byte_count != EXT_COUNT
                                || rec_offset != 16'd0)
                                code = EC_EXT_BAD;
                            else
                            begin
                                ok                    = 1'b1;
                                clear_flags           = 1'b0;
                                kind                  = FK_NONE;
                                st_next.upper_address = rec_head_word[31:16];
                            end
                        end
                        REC_START:
                        begin
                            if (st.seen_start || !st.seen_data
                                || rec_byte_count != START_COUNT || rec_offset != 16'd0)
                                code = EC_START_BAD;
                            else if (rec_head_word != cfg.entry_address)
                                code = EC_ENTRY;
                            else
                            begin
                                ok                 = 1'b1;
                                clear_flags        = 1'b0;
                                kind               = FK_NONE;
                                st_next.seen_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            code = EC_TYPE;
                        end
                    endcase
                end
            end
            CMD_FINISH:
            begin
                if (!st.upload_active || st.install_ready)
                begin
                    ok          = 1'b0;
                    clear_flags = 1'b1;
                    kind        = FK_STATE;
                    code        = EC_NOT_ACTIVE;
                end
                else if (!st.seen_eof)
                begin
                    ok          = 1'b0;
                    clear_flags = 1'b1;
                    kind        = FK_INVALID;
                    code        = EC_NO_EOF;
                end
                else
                begin
                    st_next.image_bytes   = st.next_address - cfg.image_base;
                    st_next.upload_active = 1'b0;
                    st_next.install_ready = 1'b1;
                end
            end
            default:
            begin
                clear_flags = 1'b1;
            end
        endcase

        if (clear_flags)
        begin
            st_next.upload_active = 1'b0;
            st_next.install_ready = 1'b0;
        end

        res.accepted     = ok;
        res.failure_kind = kind;
        res.error_code   = code;
        res.record_count = st_next.data_records;
        res.image_size   = st_next.image_bytes;
        res.ready_res    = st_next.install_ready;
        res.active       = st_next.upload_active;
    end

endmodule

// ----- src/hex_record_sequence_checker_core.sv -----
// Latency: an item's result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the output register takes a new result
// whenever it is empty or its result is taken in the same cycle.
// Reset clears the upload state and loads the configuration reset values.
// Depends on hrsc_pkg, hrsc_check and assert_macros.svh.
`include "assert_macros.svh"
module hex_record_sequence_checker_core
    import hrsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [31:0]          upload_length,
    input  logic [7:0]           rec_type,
    input  logic [7:0]           rec_byte_count,
    input  logic [15:0]          rec_offset,
    input  logic [31:0]          rec_head_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 accepted,
    output logic [1:0]           failure_kind,
    output logic [4:0]           error_code,
    output logic                 stage_write,
    output logic [31:0]          stage_offset,
    output logic [7:0]           stage_length,
    output logic [31:0]          record_count,
    output logic [31:0]          image_size,
    output logic                 ready_res,
    output logic                 active
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    hrsc_check u_check (
        .cfg            (cfg_reg),
        .st             (state_reg),
        .cmd            (cmd),
        .upload_length  (upload_length),
        .rec_type       (rec_type),
        .rec_byte_count (rec_byte_count),
        .rec_offset     (rec_offset),
        .rec_head_word  (rec_head_word),
        .st_next        (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_base        <= RST_IMAGE_BASE;
            cfg_reg.stage_capacity    <= RST_STAGING_CAP;
            cfg_reg.program_end       <= RST_PROGRAM_END;
            cfg_reg.max_upload_length <= RST_MAX_UPLOAD;
            cfg_reg.entry_address     <= RST_ENTRY_ADDR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_BASE:  cfg_reg.image_base        <= cfg_data;
                CFG_STAGING_CAP: cfg_reg.stage_capacity    <= cfg_data;
                CFG_PROGRAM_END: cfg_reg.program_end       <= cfg_data;
                CFG_MAX_UPLOAD:  cfg_reg.max_upload_length <= cfg_data;
                CFG_ENTRY_ADDR:  cfg_reg.entry_address     <= cfg_data;
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = res_reg.accepted;
    assign failure_kind = res_reg.failure_kind;
    assign error_code   = res_reg.error_code;
    assign stage_write  = res_reg.stage_write;
    assign stage_offset = res_reg.stage_offset;
    assign stage_length = res_reg.stage_length;
    assign record_count = res_reg.record_count;
    assign image_size   = res_reg.image_size;
    assign ready_res    = res_reg.ready_res;
    assign active       = res_reg.active;

    `ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_reg)
    `ASSERT_SAME(a_flags_exclusive, clk, rst_n, 1'b1,
        !(state_reg.upload_active && state_reg.install_ready))
    `ASSERT_SAME(a_accept_no_code, clk, rst_n, out_valid_reg && res_reg.accepted,
        res_reg.failure_kind == FK_NONE && res_reg.error_code == EC_NONE)
    `ASSERT_SAME(a_stage_only_on_accept, clk, rst_n, out_valid_reg && res_reg.stage_write,
        res_reg.accepted && res_reg.active && res_reg.stage_length != 8'd0)
    `ASSERT_NEXT(a_result_flags_match_state, clk, rst_n, in_fire,
        res_reg.active == state_reg.upload_active
        && res_reg.ready_res == state_reg.install_ready)

endmodule

// ----- dv/tb_hex_record_sequence_checker_core.sv -----
// Testbench for hex_record_sequence_checker_core: directed and random record uploads
// checked against a scoreboard that predicts every result. Depends on hrsc_pkg and the core.
// Random idling on both sides, one long receiver stall, and several configurations.
module tb_hex_record_sequence_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hrsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] upload_length;
        logic [7:0]  rec_type;
        logic [7:0]  rec_byte_count;
        logic [15:0] rec_offset;
        logic [31:0] rec_head_word;
    } upload_item_t;

    class upload_scoreboard;
        cfg_t      cfg;
        state_t    st;
        result_t   expected_q[$];
        int        errors;

        function new();
            cfg.image_base = RST_IMAGE_BASE;
            cfg.stage_capacity = RST_STAGING_CAP;
            cfg.program_end = RST_PROGRAM_END;
            cfg.max_upload_length = RST_MAX_UPLOAD;
            cfg.entry_address = RST_ENTRY_ADDR;
            st = '0;
            errors = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_IMAGE_BASE:  cfg.image_base = data;
                CFG_STAGING_CAP: cfg.stage_capacity = data;
                CFG_PROGRAM_END: cfg.program_end = data;
                CFG_MAX_UPLOAD:  cfg.max_upload_length = data;
                CFG_ENTRY_ADDR:  cfg.entry_address = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(upload_item_t it);
            result_t     r;
            logic [4:0]  code;
            logic [32:0] addr33;
            logic [32:0] end33;
            r = '0;
            code = EC_NONE;
            case (it.cmd)
                CMD_BEGIN:
                begin
                    if (st.upload_active)
                        code = EC_ACTIVE;
                    else if (st.install_ready)
                        code = EC_AWAITING;
                    else
                    begin
                        st = '0;
                        st.next_address = cfg.image_base;
                        if (it.upload_length == 0 || it.upload_length > cfg.max_upload_length)
                            code = EC_LENGTH;
                        else
                            st.upload_active = 1'b1;
                    end
                end
                CMD_RECORD:
                begin
                    if (!st.upload_active || st.install_ready)
                        code = EC_NOT_ACTIVE;
                    else if (st.seen_eof)
                        code = EC_AFTER_EOF;
                    else
                    begin
                        case (it.rec_type)
                            REC_DATA:
                            begin
                                addr33 = {1'b0, st.upper_address, 16'h0000} + 33'(it.rec_offset);
                                end33 = addr33 + 33'(it.rec_byte_count);
                                if (st.seen_start)
                                    code = EC_DATA_AFTER_ST;
                                else if (it.rec_byte_count == 0 || it.rec_offset[1:0] != 0 ||
                                         it.rec_byte_count[1:0] != 0)
                                    code = EC_MISALIGNED;
                                else if (addr33 != {1'b0, st.next_address})
                                    code = EC_GAP;
                                else if (addr33 < {1'b0, cfg.image_base} ||
                                         end33 > {1'b0, cfg.image_base} +
                                                 {1'b0, cfg.stage_capacity} ||
                                         end33 > {1'b0, cfg.program_end})
                                    code = EC_RANGE;
                                else
                                begin
                                    r.stage_write = 1'b1;
                                    r.stage_offset = addr33[31:0] - cfg.image_base;
                                    r.stage_length = it.rec_byte_count;
                                    st.next_address = end33[31:0];
                                    st.seen_data = 1'b1;
                                    st.data_records = st.data_records + 1;
                                end
                            end
                            REC_EOF:
                            begin
                                if (it.rec_byte_count != 0 || it.rec_offset != 0)
                                    code = EC_EOF_BAD;
                                else if (!st.seen_data || !st.seen_start)
                                    code = EC_MISSING;
                                else
                                    st.seen_eof = 1'b1;
                            end
                            REC_EXT:
                            begin
                                if (st.seen_start || it.rec_byte_count != EXT_COUNT ||
                                    it.rec_offset != 0)
                                    code = EC_EXT_BAD;
                                else
                                    st.upper_address = it.rec_head_word[31:16];
                            end
                            REC_START:
                            begin
                                if (st.seen_start || !st.seen_data ||
                                    it.rec_byte_count != START_COUNT || it.rec_offset != 0)
                                    code = EC_START_BAD;
                                else if (it.rec_head_word != cfg.entry_address)
                                    code = EC_ENTRY;
                                else
                                    st.seen_start = 1'b1;
                            end
                            default: code = EC_TYPE;
                        endcase
                    end
                end
                CMD_FINISH:
                begin
                    if (!st.upload_active || st.install_ready)
                        code = EC_NOT_ACTIVE;
                    else if (!st.seen_eof)
                        code = EC_NO_EOF;
                    else
                    begin
                        st.image_bytes = st.next_address - cfg.image_base;
                        st.upload_active = 1'b0;
                        st.install_ready = 1'b1;
                    end
                end
                default:
                begin
                    st.upload_active = 1'b0;
                    st.install_ready = 1'b0;
                end
            endcase

            // A begin refused while active or awaiting leaves the state alone; every other failure drops both flags.
            if (code != EC_NONE && !(code inside {EC_ACTIVE, EC_AWAITING}))
            begin
                st.upload_active = 1'b0;
                st.install_ready = 1'b0;
            end
            r.accepted = (code == EC_NONE);
            r.error_code = code;
            if (code == EC_NONE)
                r.failure_kind = FK_NONE;
            else if (code inside {EC_ACTIVE, EC_AWAITING, EC_NOT_ACTIVE})
                r.failure_kind = FK_STATE;
            else
                r.failure_kind = FK_INVALID;
            r.record_count = st.data_records;
            r.image_size = st.image_bytes;
            r.ready_res = st.install_ready;
            r.active = st.upload_active;
            expected_q.push_back(r);
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            if (errors < 30)
                $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", '0, '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted)
                report("accepted", got.accepted, want.accepted);
            if (got.failure_kind !== want.failure_kind)
                report("failure_kind", got.failure_kind, want.failure_kind);
            if (got.error_code !== want.error_code)
                report("error_code", got.error_code, want.error_code);
            if (got.stage_write !== want.stage_write)
                report("stage_write", got.stage_write, want.stage_write);
            if (got.stage_offset !== want.stage_offset)
                report("stage_offset", got.stage_offset, want.stage_offset);
            if (got.stage_length !== want.stage_length)
                report("stage_length", got.stage_length, want.stage_length);
            if (got.record_count !== want.record_count)
                report("record_count", got.record_count, want.record_count);
            if (got.image_size !== want.image_size)
                report("image_size", got.image_size, want.image_size);
            if (got.ready_res !== want.ready_res)
                report("ready_res", got.ready_res, want.ready_res);
            if (got.active !== want.active)
                report("active", got.active, want.active);
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           cmd;
    logic [31:0]          upload_length;
    logic [7:0]           rec_type;
    logic [7:0]           rec_byte_count;
    logic [15:0]          rec_offset;
    logic [31:0]          rec_head_word;
    logic                 out_valid;
    logic                 out_ready;
    logic                 accepted;
    logic [1:0]           failure_kind;
    logic [4:0]           error_code;
    logic                 stage_write;
    logic [31:0]          stage_offset;
    logic [7:0]           stage_length;
    logic [31:0]          record_count;
    logic [31:0]          image_size;
    logic                 ready_res;
    logic                 active;

    upload_scoreboard sb = new();
    int cycle_count = 0;
    int items_sent = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    hex_record_sequence_checker_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .upload_length  (upload_length),
        .rec_type       (rec_type),
        .rec_byte_count (rec_byte_count),
        .rec_offset     (rec_offset),
        .rec_head_word  (rec_head_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .failure_kind   (failure_kind),
        .error_code     (error_code),
        .stage_write    (stage_write),
        .stage_offset   (stage_offset),
        .stage_length   (stage_length),
        .record_count   (record_count),
        .image_size     (image_size),
        .ready_res      (ready_res),
        .active         (active)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({accepted, failure_kind, error_code, stage_write, stage_offset,
                             stage_length, record_count, image_size, ready_res, active});
    end

    initial
    begin : result_sink
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic upload_item_t build(logic [1:0] c, logic [31:0] len, logic [7:0] t,
                                           logic [7:0] n, logic [15:0] off, logic [31:0] head);
        upload_item_t it;
        it.cmd = c;
        it.upload_length = len;
        it.rec_type = t;
        it.rec_byte_count = n;
        it.rec_offset = off;
        it.rec_head_word = head;
        return it;
    endfunction

    task automatic send_item(input upload_item_t it);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= it.cmd;
        upload_length <= it.upload_length;
        rec_type <= it.rec_type;
        rec_byte_count <= it.rec_byte_count;
        rec_offset <= it.rec_offset;
        rec_head_word <= it.rec_head_word;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Part of a well-formed upload; now and then one field is spoiled.
    task automatic send_upload(input upload_item_t it);
        upload_item_t m;
        m = it;
        if ($urandom_range(0, 24) == 0)
        begin
            case ($urandom_range(0, 4))
                0: m.cmd = 2'($urandom);
                1: m.rec_type = 8'($urandom);
                2: m.rec_byte_count = 8'($urandom);
                3: m.rec_offset = 16'($urandom);
                default: m.rec_head_word = $urandom;
            endcase
        end
        send_item(m);
    endtask

    task automatic send_noise();
        upload_item_t it;
        it.cmd = 2'($urandom);
        it.upload_length = ($urandom_range(0, 1) == 0) ? $urandom :
                           $urandom_range(0, 2) * sb.cfg.max_upload_length;
        case ($urandom_range(0, 5))
            0: it.rec_type = REC_DATA;
            1: it.rec_type = REC_EOF;
            2: it.rec_type = REC_EXT;
            3: it.rec_type = REC_START;
            default: it.rec_type = 8'($urandom);
        endcase
        it.rec_byte_count = 8'($urandom);
        it.rec_offset = 16'($urandom);
        it.rec_head_word = $urandom;
        send_item(it);
    endtask

    task automatic run_upload();
        logic [31:0] len;
        logic [31:0] addr;
        logic [15:0] page;
        logic [7:0]  cnt;
        bit          have_page;
        int          n;
        if (sb.cfg.max_upload_length == 0)
            len = 32'd0;
        else if ($urandom_range(0, 7) == 0)
            len = sb.cfg.max_upload_length;
        else
            len = 32'd1 + ($urandom % sb.cfg.max_upload_length);
        send_upload(build(CMD_BEGIN, len, 8'($urandom), 8'($urandom), 16'($urandom), $urandom));
        addr = sb.cfg.image_base;
        have_page = 1'b0;
        page = '0;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
        repeat (n)
        begin
            if (!have_page || addr[31:16] != page || $urandom_range(0, 7) == 0)
            begin
                page = addr[31:16];
                have_page = 1'b1;
                send_upload(build(CMD_RECORD, $urandom, REC_EXT, EXT_COUNT, 16'h0000,
                                  {page, 16'($urandom)}));
            end
            cnt = 8'(4 * $urandom_range(1, ($urandom_range(0, 7) == 0) ? 63 : 16));
            send_upload(build(CMD_RECORD, $urandom, REC_DATA, cnt, addr[15:0], $urandom));
            addr = addr + cnt;
        end
        send_upload(build(CMD_RECORD, $urandom, REC_START, START_COUNT, 16'h0000,
                          sb.cfg.entry_address));
        send_upload(build(CMD_RECORD, $urandom, REC_EOF, 8'd0, 16'h0000, $urandom));
        send_upload(build(CMD_FINISH, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                          $urandom));
        if ($urandom_range(0, 1) == 0)
            send_upload(build(CMD_BEGIN, 32'd1, REC_DATA, 8'd0, 16'h0000, $urandom));
        send_upload(build(CMD_ABORT, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                          $urandom));
    endtask

    task automatic run_random(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_noise();
            else
                run_upload();
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        sb.configure(idx, data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] base, input logic [31:0] cap,
                               input logic [31:0] prog_end, input logic [31:0] max_len,
                               input logic [31:0] entry);
        cfg_write(CFG_IMAGE_BASE, base);
        cfg_write(CFG_STAGING_CAP, cap);
        cfg_write(CFG_PROGRAM_END, prog_end);
        cfg_write(CFG_MAX_UPLOAD, max_len);
        cfg_write(CFG_ENTRY_ADDR, entry);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        logic [15:0] page;
        page = RST_IMAGE_BASE[31:16];
        send_item(build(CMD_RECORD, 0, REC_DATA, 8'd4, 16'h0000, 0));
        send_item(build(CMD_FINISH, 0, REC_EOF, 8'd0, 16'h0000, 0));
        send_item(build(CMD_BEGIN, 32'd0, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_BEGIN, 32'hFFFF_FFFF, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_BEGIN, RST_MAX_UPLOAD + 1, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_BEGIN, RST_MAX_UPLOAD, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_BEGIN, 32'd1, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_RECORD, 0, REC_EXT, EXT_COUNT, 16'h0000, {page, 16'hFFFF}));
        send_item(build(CMD_RECORD, 0, REC_DATA, 8'd252, 16'h0000, 32'hFFFF_FFFF));
        send_item(build(CMD_RECORD, 0, REC_DATA, 8'd4, 16'h0100, 0));
        send_item(build(CMD_BEGIN, 32'd1, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_RECORD, 0, REC_EXT, EXT_COUNT, 16'h0000, {page, 16'h0000}));
        send_item(build(CMD_RECORD, 0, REC_DATA, 8'd8, 16'h0000, 0));
        send_item(build(CMD_RECORD, 0, REC_START, START_COUNT, 16'h0000, RST_ENTRY_ADDR));
        send_item(build(CMD_RECORD, 0, REC_EOF, 8'd0, 16'h0000, 0));
        send_item(build(CMD_RECORD, 0, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(build(CMD_BEGIN, 32'd1, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_FINISH, 0, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_BEGIN, 32'd1, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_RECORD, 0, REC_EXT, EXT_COUNT, 16'h0000, {page, 16'h0000}));
        send_item(build(CMD_RECORD, 0, REC_DATA, 8'd4, 16'h0000, 0));
        send_item(build(CMD_RECORD, 0, REC_START, START_COUNT, 16'h0000, RST_ENTRY_ADDR));
        send_item(build(CMD_RECORD, 0, REC_EOF, 8'd0, 16'h0000, 0));
        send_item(build(CMD_FINISH, 0, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_BEGIN, 32'd1, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_ABORT, 0, REC_DATA, 8'd0, 16'h0000, 0));
        send_item(build(CMD_RECORD, 0, 8'hAA, 8'd0, 16'h0000, 0));
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        cmd <= CMD_BEGIN;
        upload_length <= '0;
        rec_type <= REC_DATA;
        rec_byte_count <= '0;
        rec_offset <= '0;
        rec_head_word <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(100);
        hold_req = 1'b1;
        run_random(150);
        settle();

        load_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(120);
        settle();

        load_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_random(40);
        settle();

        load_config(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, $urandom);
        run_random(80);
        settle();

        load_config(32'h0001_FFF0, 32'h0000_0100, 32'h0002_0080, 32'h0000_1000, $urandom);
        run_random(120);
        settle();

        idle_on = 1'b0;
        load_config(RST_IMAGE_BASE, RST_STAGING_CAP, RST_PROGRAM_END, RST_MAX_UPLOAD,
                    RST_ENTRY_ADDR);
        run_random(120);
        settle();

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
